FILE: rtl/prs_pkg.sv
package prs_pkg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         slot;
        logic signed [23:0] value;
        logic [10:0]        step;
    } prs_in_t;

    typedef struct packed {
        logic [2:0]         channel;
        logic signed [23:0] out_sample;
        logic               last;
    } prs_out_t;

    localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
    localparam logic [1:0] CMD_LOAD_ADV  = 2'd1;
    localparam logic [1:0] CMD_PUSH      = 2'd2;
    localparam logic [1:0] CMD_REQUEST   = 2'd3;

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_TAP_COUNT     = 3'd1;
    localparam logic [2:0] REG_BLOCK_COUNT   = 3'd2;
    localparam logic [2:0] REG_ADVANCE_COUNT = 3'd3;
    localparam logic [2:0] REG_BUFFER_LENGTH = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CH_START,
        ST_TAP,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT,
        ST_ADV_FETCH,
        ST_ADV_MOD,
        ST_ADV
    } prs_state_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mac;
    } prs_mac_ctl_t;

endpackage

FILE: rtl/prs_mac.sv
module prs_mac
    import prs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  prs_mac_ctl_t        ctl,
    input  logic signed [23:0]  coef,
    input  logic signed [23:0]  sample,
    output logic signed [23:0]  result
);

    logic signed [47:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [55:0] acc_reg;
    logic signed [55:0] acc_next;
    logic signed [55:0] rounded;
    logic signed [32:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.mac;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + 56'(prod_reg);
        end
    end

    // Round half up, then saturate to 24 bits.
    assign rounded = acc_reg + 56'sd4194304;
    assign shifted = rounded[55:23];

    always_comb
    begin
        if (shifted > 33'sd8388607)
        begin
            result = 24'sh7FFFFF;
        end
        else if (shifted < -33'sd8388608)
        begin
            result = 24'sh800000;
        end
        else
        begin
            result = shifted[23:0];
        end
    end

endmodule

FILE: rtl/polyphase_resampler_top.sv
// Polyphase resampler. Each input word is a command: load a coefficient,
// load a read advance, push a sample into a channel's circular buffer, or
// request output. A load or push is registered and executed after
// acceptance, and no input word is accepted until it is done. An output
// request produces one word per active channel, the last one flagged; each
// result is a dot product of tap_count coefficients with buffer samples,
// computed by one shared multiply-accumulate unit at one tap per cycle
// through the single sample memory read port and the multiply-accumulate
// pipeline, followed by a bit-serial reduction of the read advance modulo
// the buffer length. A stalled result word holds the sequencer before the
// next channel's result is posted. After reset the sample memory is cleared
// in a pass over all CHANNELS * BUF_DEPTH words, during which no input word
// is accepted. The user must write configuration only while the block is
// idle; the block itself does not enforce this. Writing buffer_length
// resets every write position and read position.
module polyphase_resampler_top
    import prs_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int BUF_DEPTH  = 1024,
    parameter int COEF_DEPTH = 1024,
    parameter int ADV_DEPTH  = 64,
    parameter int MAX_TAPS   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  prs_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output prs_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BW   = $clog2(BUF_DEPTH);
    localparam int LW   = BW + 1;
    localparam int SW   = CW + BW;
    localparam int CAW  = $clog2(COEF_DEPTH);
    localparam int AW   = (ADV_DEPTH > 1) ? $clog2(ADV_DEPTH) : 1;
    localparam int TW   = $clog2(MAX_TAPS + 1);
    localparam int MAXC = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int SDEPTH = CHANNELS * BUF_DEPTH;
    localparam int RST_LEN = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

    // Configuration registers.
    logic [3:0]  chan_cnt_reg;
    logic [6:0]  tap_cnt_reg;
    logic [6:0]  blk_cnt_reg;
    logic [6:0]  adv_cnt_reg;
    logic [10:0] buf_len_reg;

    // Effective (clamped) settings.
    logic [CW:0] nch;
    logic [TW-1:0] ntaps;
    logic [6:0]  nblk;
    logic [10:0] nadv;
    logic [LW-1:0] len;

    always_comb
    begin
        nch = (chan_cnt_reg == 4'd0) ? (CW+1)'(1)
            : (32'(chan_cnt_reg) > MAXC) ? (CW+1)'(MAXC) : (CW+1)'(chan_cnt_reg);
        ntaps = (tap_cnt_reg == 7'd0) ? TW'(1)
              : (32'(tap_cnt_reg) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_cnt_reg);
        nblk = (blk_cnt_reg == 7'd0) ? 7'd1 : blk_cnt_reg;
        nadv = (adv_cnt_reg == 7'd0) ? 11'd1
             : (32'(adv_cnt_reg) > ADV_DEPTH) ? 11'(ADV_DEPTH) : 11'(adv_cnt_reg);
        len = (buf_len_reg < 11'd2) ? LW'(2)
            : (32'(buf_len_reg) > BUF_DEPTH) ? LW'(BUF_DEPTH) : LW'(buf_len_reg);
    end

    // Position registers.
    logic [BW-1:0] wpos_reg [CHANNELS];
    logic [BW-1:0] rpos_reg [CHANNELS];
    logic [6:0]    blk_idx_reg;
    logic [5:0]    adv_idx_reg;

    // Memories.
    logic signed [23:0] sample_mem [SDEPTH];
    logic signed [23:0] coef_mem   [COEF_DEPTH];
    logic [10:0]        adv_mem    [ADV_DEPTH];

    prs_state_t state_reg, state_next;

    logic [SW-1:0]  clr_addr_reg;
    logic [CW-1:0]  ch_reg;
    logic [TW-1:0]  tap_reg;
    logic [BW-1:0]  p_reg;
    logic [CAW-1:0] caddr_reg;
    logic [CAW-1:0] base_reg;
    logic [2:0]     drain_reg;
    logic [10:0]    adv_val_reg;
    logic [LW-1:0]  rem_reg;
    logic [LW-1:0]  rem_next;
    logic [LW:0]    rem_sh;
    logic [3:0]     mod_bit_reg;
    prs_in_t        cmd_reg;
    prs_out_t       out_reg;
    logic           out_vld_reg;

    logic signed [23:0] s_rd_reg;
    logic signed [23:0] c_rd_reg;
    logic signed [23:0] mac_result;
    prs_mac_ctl_t       mac_ctl;

    logic               in_fire;
    logic               cfg_fire;
    logic               last_ch;

    // A load or push is executed in the cycle after acceptance.
    logic cmd_pend_reg;

    // Adds a reduced advance to a read position and wraps once.
    function automatic logic [LW-1:0] adv_mod(input logic [LW-1:0] pos,
                                              input logic [LW-1:0] r,
                                              input logic [LW-1:0] l);
        logic [LW:0] s;
        begin
            s = (LW+1)'(pos) + (LW+1)'(r);
            if (s >= (LW+1)'(l))
            begin
                s = s - (LW+1)'(l);
            end
            adv_mod = LW'(s);
        end
    endfunction

    assign in_ready  = (state_reg == ST_IDLE) && !cmd_pend_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign last_ch   = ((CW+1)'(ch_reg) + 1'b1) == nch;

    // One restoring step of the advance modulo the buffer length, most
    // significant bit first.
    always_comb
    begin
        rem_sh   = {rem_reg, adv_val_reg[mod_bit_reg]};
        rem_next = (rem_sh >= (LW+1)'(len)) ? LW'(rem_sh - (LW+1)'(len)) : LW'(rem_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= 4'd1;
            tap_cnt_reg  <= 7'd16;
            blk_cnt_reg  <= 7'd1;
            adv_cnt_reg  <= 7'd1;
            buf_len_reg  <= 11'd256;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: chan_cnt_reg <= cfg_data[3:0];
                REG_TAP_COUNT:     tap_cnt_reg  <= cfg_data[6:0];
                REG_BLOCK_COUNT:   blk_cnt_reg  <= cfg_data[6:0];
                REG_ADVANCE_COUNT: adv_cnt_reg  <= cfg_data[6:0];
                REG_BUFFER_LENGTH: buf_len_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.cmd == CMD_REQUEST)
                begin
                    state_next = ST_CH_START;
                end
            end
            ST_CLEAR:
            begin
                if (32'(clr_addr_reg) == SDEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CH_START: state_next = ST_TAP;
            ST_TAP:
            begin
                if (tap_reg == ntaps - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 3'd2)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (!out_vld_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = last_ch ? ST_ADV_FETCH : ST_CH_START;
            end
            ST_ADV_FETCH: state_next = ST_ADV_MOD;
            ST_ADV_MOD:
            begin
                if (mod_bit_reg == 4'd0)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (32'(ch_reg) == CHANNELS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_ctl.clear = (state_reg == ST_CH_START);
        mac_ctl.mac   = (state_reg == ST_TAP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cmd_pend_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
            blk_idx_reg  <= '0;
            adv_idx_reg  <= '0;
            ch_reg       <= '0;
            tap_reg      <= '0;
            drain_reg    <= '0;
            p_reg        <= '0;
            caddr_reg    <= '0;
            base_reg     <= '0;
            adv_val_reg  <= '0;
            rem_reg      <= '0;
            mod_bit_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wpos_reg[i] <= '0;
                rpos_reg[i] <= BW'(RST_LEN / 2 - 1);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_vld_reg && out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            cmd_pend_reg <= in_fire && in_data.cmd != CMD_REQUEST;

            if (cfg_fire && cfg_index == REG_BUFFER_LENGTH)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    wpos_reg[i] <= '0;
                    if (cfg_data < 11'd2)
                    begin
                        rpos_reg[i] <= '0;
                    end
                    else if (32'(cfg_data) > BUF_DEPTH)
                    begin
                        rpos_reg[i] <= BW'(BUF_DEPTH / 2 - 1);
                    end
                    else
                    begin
                        rpos_reg[i] <= BW'(cfg_data[10:1] - 10'd1);
                    end
                end
            end

            if (cmd_pend_reg && cmd_reg.cmd == CMD_PUSH
                && 32'(cmd_reg.slot) < 32'(nch))
            begin
                if (LW'(wpos_reg[CW'(cmd_reg.slot)]) + 1'b1 >= len)
                begin
                    wpos_reg[CW'(cmd_reg.slot)] <= '0;
                end
                else
                begin
                    wpos_reg[CW'(cmd_reg.slot)] <= wpos_reg[CW'(cmd_reg.slot)] + 1'b1;
                end
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    ch_reg   <= '0;
                    base_reg <= CAW'(32'(blk_idx_reg) * 32'(ntaps));
                end
                ST_CH_START:
                begin
                    tap_reg   <= '0;
                    drain_reg <= '0;
                    p_reg     <= rpos_reg[ch_reg];
                    caddr_reg <= base_reg;
                end
                ST_TAP:
                begin
                    tap_reg   <= tap_reg + 1'b1;
                    caddr_reg <= caddr_reg + 1'b1;
                    if (LW'(p_reg) + 1'b1 >= len)
                    begin
                        p_reg <= '0;
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                end
                ST_ROUND:
                begin
                    if (!out_vld_reg)
                    begin
                        out_vld_reg        <= 1'b1;
                        out_reg.channel    <= 3'(ch_reg);
                        out_reg.out_sample <= mac_result;
                        out_reg.last       <= last_ch;
                    end
                end
                ST_OUT:
                begin
                    if (last_ch)
                    begin
                        ch_reg <= '0;
                        blk_idx_reg <= (blk_idx_reg + 7'd1 >= nblk)
                                     ? 7'd0 : blk_idx_reg + 7'd1;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_ADV_FETCH:
                begin
                    adv_val_reg <= adv_mem[AW'(adv_idx_reg)];
                    rem_reg     <= '0;
                    mod_bit_reg <= 4'd10;
                end
                ST_ADV_MOD:
                begin
                    rem_reg     <= rem_next;
                    mod_bit_reg <= mod_bit_reg - 4'd1;
                end
                ST_ADV:
                begin
                    // One channel per cycle: the advance is already reduced
                    // below the length, so a single wrap is enough.
                    rpos_reg[ch_reg] <= BW'(adv_mod(LW'(rpos_reg[ch_reg]), rem_reg, len));
                    ch_reg <= ch_reg + 1'b1;
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        adv_idx_reg <= (11'(adv_idx_reg) + 11'd1 >= nadv)
                                     ? 6'd0 : adv_idx_reg + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_data;
        end
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            sample_mem[clr_addr_reg] <= '0;
        end
        else if (cmd_pend_reg && cmd_reg.cmd == CMD_PUSH
                 && 32'(cmd_reg.slot) < 32'(nch))
        begin
            sample_mem[{CW'(cmd_reg.slot), wpos_reg[CW'(cmd_reg.slot)]}] <= cmd_reg.value;
        end
        s_rd_reg <= sample_mem[{ch_reg, p_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pend_reg && cmd_reg.cmd == CMD_LOAD_COEF
            && 32'(cmd_reg.slot) < COEF_DEPTH)
        begin
            coef_mem[CAW'(cmd_reg.slot)] <= cmd_reg.value;
        end
        c_rd_reg <= coef_mem[caddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pend_reg && cmd_reg.cmd == CMD_LOAD_ADV
            && 32'(cmd_reg.slot) < ADV_DEPTH)
        begin
            adv_mem[AW'(cmd_reg.slot)] <= cmd_reg.step;
        end
    end

    // The read data is registered after the address; the MAC valid is delayed by a register to match.
    logic mac_en_reg;
    prs_mac_ctl_t mac_ctl_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_en_reg <= 1'b0;
        end
        else
        begin
            mac_en_reg <= mac_ctl.mac;
        end
    end

    always_comb
    begin
        mac_ctl_d.clear = mac_ctl.clear;
        mac_ctl_d.mac   = mac_en_reg;
    end

    prs_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl_d),
        .coef   (c_rd_reg),
        .sample (s_rd_reg),
        .result (mac_result)
    );

endmodule

FILE: rtl/prs_checker.sv
module prs_checker
    import prs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input prs_out_t out_data
);

    // A result word holds while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // An offered result word is fully defined.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result word has unknown bits");

    // An accepted input word makes the block busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready did not drop after accept");

endmodule

bind polyphase_resampler_top prs_checker u_prs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
